[rtl/radar_sweep_controller_defines.svh]
// Assertion macros used by the radar sweep controller top level.
`ifndef RADAR_SWEEP_CONTROLLER_DEFINES_SVH
`define RADAR_SWEEP_CONTROLLER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RSC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rsc_pkg.sv]
// Types, constants and register codes of the radar sweep controller.
package rsc_pkg;

  localparam int ECHO_COUNT_WIDTH_DEF = 16;

  localparam int RANGE_W  = 14;
  localparam int ANGLE_W  = 8;
  localparam int STEP_W   = 6;
  localparam int PULSE_W  = 16;
  localparam int PPD_W    = 8;
  localparam int CM_W     = 7;

  // ticks * 1.085us * 34300cm/s / 2 * 100, as a 16-bit fraction
  localparam int                 RANGE_FACTOR_W = 17;
  localparam logic [16:0]        RANGE_FACTOR   = 17'd121948;
  localparam int                 RANGE_SHIFT    = 16;
  localparam logic [RANGE_W-1:0] RANGE_CLAMP    = 14'd9999;

  // x / 100 == (x * 5243) >> 19 for every x up to 9999
  localparam int          CM_RECIP_W = 13;
  localparam logic [12:0] CM_RECIP   = 13'd5243;
  localparam int          CM_SHIFT   = 19;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEAR_LIMIT,
    REG_FAR_LIMIT,
    REG_ANGLE_STEP,
    REG_ANGLE_MAX,
    REG_PULSE_BASE,
    REG_PULSE_PER_DEG,
    REG_FRAME_LEN
  } reg_index_t;

  localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 14'd200;
  localparam logic [RANGE_W-1:0] FAR_LIMIT_RST  = 14'd2000;
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST = 6'd5;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST  = 8'd180;
  localparam logic [PULSE_W-1:0] PULSE_BASE_RST = 16'd922;
  localparam logic [PPD_W-1:0]   PULSE_PPD_RST  = 8'd6;
  localparam logic [PULSE_W-1:0] FRAME_LEN_RST  = 16'd18433;

  localparam int OUT_FIELDS_W = ANGLE_W + 2 * PULSE_W + 2 * RANGE_W + 3 + CM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [RANGE_W-1:0] near_limit;
    logic [RANGE_W-1:0] far_limit;
    logic [STEP_W-1:0]  angle_step;
    logic [ANGLE_W-1:0] angle_max;
    logic [PULSE_W-1:0] pulse_base;
    logic [PPD_W-1:0]   pulse_per_degree;
    logic [PULSE_W-1:0] frame_len;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [RANGE_W-1:0] range_a;
    logic [RANGE_W-1:0] range_b;
    logic               hit_a;
    logic               hit_b;
  } scan_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               sweeping_up;
  } sweep_state_t;

endpackage

[rtl/rsc_range_lane.sv]
// One sensor lane: echo ticks to clamped distance and window hit.
module rsc_range_lane
  import rsc_pkg::*;
#(
  parameter int ECHO_W = ECHO_COUNT_WIDTH_DEF
) (
  input  logic [ECHO_W-1:0]  ticks,
  input  logic [RANGE_W-1:0] near_limit,
  input  logic [RANGE_W-1:0] far_limit,
  output logic [RANGE_W-1:0] range,
  output logic               hit
);

  localparam int PROD_W   = ECHO_W + RANGE_FACTOR_W;
  localparam int SCALED_W = PROD_W - RANGE_SHIFT;
  localparam int CMP_W    = (SCALED_W > RANGE_W) ? SCALED_W : RANGE_W;

  logic [PROD_W-1:0]   product;
  logic [SCALED_W-1:0] scaled;
  logic [CMP_W-1:0]    scaled_ext;

  assign product    = PROD_W'(ticks) * PROD_W'(RANGE_FACTOR);
  assign scaled     = product[PROD_W-1:RANGE_SHIFT];
  assign scaled_ext = CMP_W'(scaled);

  always_comb begin
    if (scaled_ext > CMP_W'(RANGE_CLAMP)) begin
      range = RANGE_CLAMP;
    end else begin
      range = scaled_ext[RANGE_W-1:0];
    end
  end

  assign hit = (range > near_limit) && (range < far_limit);

endmodule

[rtl/rsc_merge.sv]
// Sweep state and the scan register that combines both lane results.
module rsc_merge
  import rsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RANGE_W-1:0] range_a,
  input  logic [RANGE_W-1:0] range_b,
  input  logic               hit_a,
  input  logic               hit_b,
  output logic               scan_valid,
  input  logic               scan_ready,
  output scan_t              scan,
  output sweep_state_t       sweep
);

  logic               accept;
  logic [ANGLE_W:0]   angle_up;
  logic [ANGLE_W:0]   angle_moved;
  logic [ANGLE_W-1:0] angle_next;
  logic               sweeping_up_next;

  assign in_ready = !scan_valid || scan_ready;
  assign accept   = in_valid && in_ready;

  assign angle_up = {1'b0, sweep.angle} + (ANGLE_W + 1)'(cfg.angle_step);

  always_comb begin
    if (sweep.sweeping_up) begin
      angle_moved = angle_up;
    end else if (sweep.angle >= ANGLE_W'(cfg.angle_step)) begin
      angle_moved = {1'b0, sweep.angle - ANGLE_W'(cfg.angle_step)};
    end else begin
      angle_moved = '0;
    end
    if (angle_moved > {1'b0, cfg.angle_max}) begin
      angle_next = cfg.angle_max;
    end else begin
      angle_next = angle_moved[ANGLE_W-1:0];
    end
  end

  // B wins over A; the end stops win over both
  always_comb begin
    sweeping_up_next = sweep.sweeping_up;
    if (hit_a) begin
      sweeping_up_next = 1'b0;
    end
    if (hit_b) begin
      sweeping_up_next = 1'b1;
    end
    if (angle_next == cfg.angle_max) begin
      sweeping_up_next = 1'b0;
    end else if (angle_next == '0) begin
      sweeping_up_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep.angle       <= '0;
      sweep.sweeping_up <= 1'b1;
      scan_valid        <= 1'b0;
    end else begin
      if (accept) begin
        sweep.angle       <= angle_next;
        sweep.sweeping_up <= sweeping_up_next;
        scan_valid        <= 1'b1;
      end else if (scan_ready) begin
        scan_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan.angle   <= angle_next;
      scan.range_a <= range_a;
      scan.range_b <= range_b;
      scan.hit_a   <= hit_a;
      scan.hit_b   <= hit_b;
    end
  end

endmodule

[rtl/rsc_out_stage.sv]
// Servo timing, centimetre conversion and the output register.
module rsc_out_stage
  import rsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   scan_valid,
  output logic                   scan_ready,
  input  scan_t                  scan,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CM_PROD_W = RANGE_W + CM_RECIP_W;
  localparam int PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  logic                 load;
  logic [PULSE_W-1:0]   angle_pulse;
  logic [PULSE_W:0]     high_sum;
  logic [PULSE_W-1:0]   high_ticks;
  logic [PULSE_W-1:0]   low_ticks;
  logic [CM_PROD_W-1:0] cm_prod;
  logic [CM_W-1:0]      range_cm;
  logic                 alarm;

  assign scan_ready = !m_tvalid || m_tready;
  assign load       = scan_valid && scan_ready;

  assign angle_pulse = PULSE_W'(scan.angle) * PULSE_W'(cfg.pulse_per_degree);
  assign high_sum    = {1'b0, cfg.pulse_base} + {1'b0, angle_pulse};
  assign high_ticks  = high_sum[PULSE_W] ? '1 : high_sum[PULSE_W-1:0];
  assign low_ticks   = (cfg.frame_len > high_ticks) ? cfg.frame_len - high_ticks : '0;

  assign cm_prod  = CM_PROD_W'(scan.range_a) * CM_PROD_W'(CM_RECIP);
  assign range_cm = cm_prod[CM_SHIFT + CM_W - 1:CM_SHIFT];
  assign alarm    = scan.hit_a || scan.hit_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {PAD_W'(0), range_cm, alarm, scan.hit_b, scan.hit_a,
                  scan.range_b, scan.range_a, low_ticks, high_ticks, scan.angle};
    end
  end

endmodule

[rtl/radar_sweep_controller.sv]
// Radar sweep controller top level: config registers, two range lanes, merge, output.
//
//  channel   | signals                            | content
//  ----------+------------------------------------+---------------------------------
//  scan in   | s_tvalid s_tready s_tdata          | one scan: both echo tick counts
//  result    | m_tvalid m_tready m_tdata          | angle, servo ticks, ranges, flags
//  config    | cfg_wr_en cfg_index cfg_data       | register writes, no read-back
//
// One scan per cycle sustained while m_tready holds; a scan passes the scan register, then the output register.
// First: both range lanes multiply and compare while the angle and direction update, into the scan register.
// Then: servo pulse multiply and the /100 reciprocal multiply fill the output register.
// Reset (rst, synchronous) sets the angle to 0, sweeping up, and registers to defaults.
// A stalled result holds; a new scan is still taken while the scan register can move on.
module radar_sweep_controller
  import rsc_pkg::*;
#(
  parameter int ECHO_COUNT_WIDTH = ECHO_COUNT_WIDTH_DEF,
  localparam int IN_TDATA_W = ((2 * ECHO_COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // echo_ticks_a, echo_ticks_b, zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // sweep_angle, servo_high_ticks, servo_low_ticks, range_a, range_b,
  // hit_a, hit_b, alarm, range_a_cm, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "radar_sweep_controller_defines.svh"

  cfg_t               cfg;
  logic [RANGE_W-1:0] lane_range [2];
  logic               lane_hit [2];
  logic [ECHO_COUNT_WIDTH-1:0] lane_ticks [2];
  logic               scan_valid;
  logic               scan_ready;
  scan_t              scan;
  sweep_state_t       sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit       <= NEAR_LIMIT_RST;
      cfg.far_limit        <= FAR_LIMIT_RST;
      cfg.angle_step       <= ANGLE_STEP_RST;
      cfg.angle_max        <= ANGLE_MAX_RST;
      cfg.pulse_base       <= PULSE_BASE_RST;
      cfg.pulse_per_degree <= PULSE_PPD_RST;
      cfg.frame_len        <= FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_NEAR_LIMIT:    cfg.near_limit       <= cfg_data[RANGE_W-1:0];
        REG_FAR_LIMIT:     cfg.far_limit        <= cfg_data[RANGE_W-1:0];
        REG_ANGLE_STEP:    cfg.angle_step       <= cfg_data[STEP_W-1:0];
        REG_ANGLE_MAX:     cfg.angle_max        <= cfg_data[ANGLE_W-1:0];
        REG_PULSE_BASE:    cfg.pulse_base       <= cfg_data[PULSE_W-1:0];
        REG_PULSE_PER_DEG: cfg.pulse_per_degree <= cfg_data[PPD_W-1:0];
        REG_FRAME_LEN:     cfg.frame_len        <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign lane_ticks[0] = s_tdata[ECHO_COUNT_WIDTH-1:0];
  assign lane_ticks[1] = s_tdata[2*ECHO_COUNT_WIDTH-1:ECHO_COUNT_WIDTH];

  for (genvar i = 0; i < 2; i++) begin : g_lane
    rsc_range_lane #(
      .ECHO_W(ECHO_COUNT_WIDTH)
    ) u_lane (
      .ticks      (lane_ticks[i]),
      .near_limit (cfg.near_limit),
      .far_limit  (cfg.far_limit),
      .range      (lane_range[i]),
      .hit        (lane_hit[i])
    );
  end

  rsc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .range_a    (lane_range[0]),
    .range_b    (lane_range[1]),
    .hit_a      (lane_hit[0]),
    .hit_b      (lane_hit[1]),
    .scan_valid (scan_valid),
    .scan_ready (scan_ready),
    .scan       (scan),
    .sweep      (sweep)
  );

  rsc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .scan_valid (scan_valid),
    .scan_ready (scan_ready),
    .scan       (scan),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  `RSC_ASSERT_IMPLIES(a_angle_in_sweep, scan_valid, scan.angle <= cfg.angle_max,
                      "scan angle above angle_max")
  `RSC_ASSERT_IMPLIES(a_hit_in_window, scan_valid && scan.hit_a,
                      scan.range_a > cfg.near_limit && scan.range_a < cfg.far_limit,
                      "hit_a set outside the detection window")
  `RSC_ASSERT_IMPLIES(a_floor_turns_up,
                      scan_valid && sweep.angle == '0 && cfg.angle_max != '0,
                      sweep.sweeping_up, "sweep at zero degrees not turned upward")

endmodule
